### rtl/core/piecewise_linear_curve_eval_unit_assert.svh
// Assertion macros for the piecewise-linear curve evaluation unit.
`ifndef PIECEWISE_LINEAR_CURVE_EVAL_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_CURVE_EVAL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PWL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked during reset as well.
`define PWL_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/pwl_pkg.sv
// Package with curve tables, widths and stage types of the curve evaluation unit.
`default_nettype none

package pwl_pkg;

   localparam int POINTS     = 22;
   localparam int RATIO_W    = 16;
   localparam int VALUE_W    = 15;
   localparam int SEG_W      = 5;
   localparam int OFS_W      = 10;
   localparam int SLOPE_W    = 20;
   localparam int SLOPE_FRAC = 16;
   localparam int PROD_W     = OFS_W + SLOPE_W;
   localparam int MAG_W      = PROD_W + 1 - SLOPE_FRAC;
   localparam int SUM_W      = VALUE_W + 2;

   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (SLOPE_FRAC - 1);

   localparam logic signed [RATIO_W-1:0] BX [POINTS] = '{
      16'sd0,    16'sd406,  16'sd812,  16'sd1218, 16'sd1624, 16'sd2029,
      16'sd2434, 16'sd2838, 16'sd3241, 16'sd3645, 16'sd4049, 16'sd4454,
      16'sd4861, 16'sd5270, 16'sd5681, 16'sd6096, 16'sd6512, 16'sd6931,
      16'sd7350, 16'sd7771, 16'sd8192, 16'sd9011
   };

   localparam logic [VALUE_W-1:0] VY [POINTS] = '{
      15'd1638,  15'd4827,  15'd7881,  15'd10665, 15'd13044, 15'd14884,
      15'd16049, 15'd16406, 15'd15945, 15'd14842, 15'd13291, 15'd11486,
      15'd9621,  15'd7887,  15'd6468,  15'd5399,  15'd4623,  15'd4081,
      15'd3715,  15'd3467,  15'd3277,  15'd0
   };

   // Slope magnitudes per segment; the last entry belongs to the clamp above the curve.
   localparam logic [SLOPE_W-1:0] SLOPE_MAG [POINTS] = '{
      20'd514764, 20'd492973, 20'd449390, 20'd384015, 20'd297744, 20'd188517,
      20'd57912,  20'd74968,  20'd178926, 20'd251600, 20'd292080, 20'd300306,
      20'd277847, 20'd226267, 20'd168814, 20'd122250, 20'd84774,  20'd57246,
      20'd38606,  20'd29577,  20'd262224, 20'd0
   };

   localparam logic SLOPE_NEG [POINTS] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
   };

   typedef struct packed {
      logic                      valid;
      logic                      clamp;
      logic [SEG_W-1:0]          seg;
      logic signed [RATIO_W-1:0] ratio;
   } seg_stage_type;

   typedef struct packed {
      logic               valid;
      logic [OFS_W-1:0]   offset;
      logic [SLOPE_W-1:0] slope_mag;
      logic               slope_neg;
      logic [VALUE_W-1:0] base;
   } coef_stage_type;

   typedef struct packed {
      logic               valid;
      logic [PROD_W-1:0]  prod_mag;
      logic               neg;
      logic [VALUE_W-1:0] base;
   } prod_stage_type;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
   } out_stage_type;

endpackage

`default_nettype wire

### rtl/core/pwl_if.sv
// Request and response channel interfaces of the curve evaluation unit.
`default_nettype none

interface pwl_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [pwl_pkg::RATIO_W-1:0]         ratio;

   modport source (output valid, output ratio, input ready);
   modport sink (input valid, input ratio, output ready);
endinterface

interface pwl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pwl_pkg::VALUE_W-1:0]       curve_value;

   modport source (output valid, output curve_value, input ready);
   modport sink (input valid, input curve_value, output ready);
endinterface

`default_nettype wire

### rtl/core/pwl_seg_find.sv
// First stage: breakpoint compares, segment select and clamp detection.
`default_nettype none

module pwl_seg_find (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                in_valid,
   input  wire logic signed [pwl_pkg::RATIO_W-1:0]  in_ratio,
   output pwl_pkg::seg_stage_type                   seg_out
);

   pwl_pkg::seg_stage_type seg_in;
   pwl_pkg::seg_stage_type seg_ff;

   always_comb begin
      logic below;
      logic above;
      logic [pwl_pkg::SEG_W-1:0] seg_idx;
      below   = in_ratio < pwl_pkg::BX[0];
      above   = in_ratio >= pwl_pkg::BX[pwl_pkg::POINTS-1];
      seg_idx = '0;
      for (int k = 1; k < pwl_pkg::POINTS - 1; k++) begin
         if (in_ratio >= pwl_pkg::BX[k]) begin
            seg_idx = pwl_pkg::SEG_W'(k);
         end
      end
      seg_in.valid = in_valid;
      seg_in.clamp = below | above;
      seg_in.ratio = in_ratio;
      if (below) begin
         seg_in.seg = '0;
      end else if (above) begin
         seg_in.seg = pwl_pkg::SEG_W'(pwl_pkg::POINTS - 1);
      end else begin
         seg_in.seg = seg_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff.valid <= 1'b0;
      end else if (advance) begin
         seg_ff <= seg_in;
      end
   end

   assign seg_out = seg_ff;

endmodule

`default_nettype wire

### rtl/core/pwl_coef.sv
// Second stage: segment offset and slope and base value lookup.
`default_nettype none

module pwl_coef (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  pwl_pkg::seg_stage_type      seg_in,
   output pwl_pkg::coef_stage_type     coef_out
);

   pwl_pkg::coef_stage_type coef_in;
   pwl_pkg::coef_stage_type coef_ff;

   always_comb begin
      logic signed [pwl_pkg::RATIO_W-1:0] diff;
      diff = seg_in.ratio - pwl_pkg::BX[seg_in.seg];
      coef_in.valid     = seg_in.valid;
      coef_in.offset    = seg_in.clamp ? '0 : diff[pwl_pkg::OFS_W-1:0];
      coef_in.slope_mag = seg_in.clamp ? '0 : pwl_pkg::SLOPE_MAG[seg_in.seg];
      coef_in.slope_neg = pwl_pkg::SLOPE_NEG[seg_in.seg];
      coef_in.base      = pwl_pkg::VY[seg_in.seg];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.valid <= 1'b0;
      end else if (advance) begin
         coef_ff <= coef_in;
      end
   end

   assign coef_out = coef_ff;

endmodule

`default_nettype wire

### rtl/core/pwl_mac.sv
// Third and fourth stages: slope multiply, rounding, base add and saturation.
`default_nettype none

module pwl_mac (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  pwl_pkg::coef_stage_type     coef_in,
   output pwl_pkg::out_stage_type      out_stage
);

   pwl_pkg::prod_stage_type prod_in;
   pwl_pkg::prod_stage_type prod_ff;
   pwl_pkg::out_stage_type  out_in;
   pwl_pkg::out_stage_type  out_ff;

   always_comb begin
      prod_in.valid    = coef_in.valid;
      prod_in.prod_mag = pwl_pkg::PROD_W'(coef_in.offset) * pwl_pkg::PROD_W'(coef_in.slope_mag);
      prod_in.neg      = coef_in.slope_neg;
      prod_in.base     = coef_in.base;
   end

   always_comb begin
      logic [pwl_pkg::PROD_W:0]          rnd;
      logic [pwl_pkg::MAG_W-1:0]         mag;
      logic signed [pwl_pkg::SUM_W-1:0]  sum;
      rnd = {1'b0, prod_ff.prod_mag} + pwl_pkg::ROUND_HALF;
      mag = rnd[pwl_pkg::PROD_W:pwl_pkg::SLOPE_FRAC];
      if (prod_ff.neg) begin
         sum = $signed(pwl_pkg::SUM_W'(prod_ff.base)) - $signed(pwl_pkg::SUM_W'(mag));
      end else begin
         sum = $signed(pwl_pkg::SUM_W'(prod_ff.base)) + $signed(pwl_pkg::SUM_W'(mag));
      end
      out_in.valid = prod_ff.valid;
      if (sum[pwl_pkg::SUM_W-1]) begin
         out_in.value = '0;
      end else if (sum[pwl_pkg::SUM_W-2:pwl_pkg::VALUE_W] != '0) begin
         out_in.value = '1;
      end else begin
         out_in.value = sum[pwl_pkg::VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else if (advance) begin
         prod_ff <= prod_in;
         out_ff  <= out_in;
      end
   end

   assign out_stage = out_ff;

endmodule

`default_nettype wire

### rtl/core/piecewise_linear_curve_eval_unit.sv
// Top level of the piecewise-linear curve evaluation unit.
//
//   Channel   Direction  Payload
//   req_if    in         ratio, signed Q2.13
//   rsp_if    out        curve_value, unsigned Q1.14
//
// The pipeline has four register stages: segment compare, table lookup, multiply,
// and round with saturation into the output register.
// A request is accepted every cycle unless a valid response is stalled.
// Reset clears the stage valid bits only.
// A stalled response freezes all stages together, so nothing is lost or repeated.
`default_nettype none

`include "piecewise_linear_curve_eval_unit_assert.svh"

module piecewise_linear_curve_eval_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   pwl_req_if.sink    req_if,
   pwl_rsp_if.source  rsp_if
);

   logic                     advance;
   pwl_pkg::seg_stage_type   seg_stage;
   pwl_pkg::coef_stage_type  coef_stage;
   pwl_pkg::out_stage_type   out_stage;

   assign advance = ~out_stage.valid | rsp_if.ready;

   pwl_seg_find u_seg_find (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_if.valid),
      .in_ratio (req_if.ratio),
      .seg_out  (seg_stage)
   );

   pwl_coef u_coef (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .seg_in   (seg_stage),
      .coef_out (coef_stage)
   );

   pwl_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .coef_in   (coef_stage),
      .out_stage (out_stage)
   );

   assign req_if.ready       = advance;
   assign rsp_if.valid       = out_stage.valid;
   assign rsp_if.curve_value = out_stage.value;

   `PWL_ASSERT_NOW(a_no_accept_on_stall, clock, reset, rsp_if.valid && !rsp_if.ready, !req_if.ready, "request accepted while response stalled")
   `PWL_ASSERT_NEXT(a_reset_clears_output, clock, reset, !rsp_if.valid, "response valid right after reset")
   `PWL_ASSERT_NEXT(a_stall_holds_stage, clock, !advance && !reset, $stable(seg_stage) && $stable(coef_stage), "pipeline stage changed during stall")

endmodule

`default_nettype wire

### verif/tb_piecewise_linear_curve_eval_unit.sv
// Testbench for the piecewise-linear curve evaluation unit with a curve predictor and scoreboard.
`timescale 1ns / 1ps

class curve_value_checker;
   int knot_x [22] = '{
      0, 406, 812, 1218, 1624, 2029, 2434, 2838, 3241, 3645, 4049,
      4454, 4861, 5270, 5681, 6096, 6512, 6931, 7350, 7771, 8192, 9011
   };
   int knot_y [22] = '{
      1638, 4827, 7881, 10665, 13044, 14884, 16049, 16406, 15945, 14842, 13291,
      11486, 9621, 7887, 6468, 5399, 4623, 4081, 3715, 3467, 3277, 0
   };
   logic [14:0] expected_values [$];
   int mismatches;

   function int pending();
      return expected_values.size();
   endfunction

   function logic [14:0] curve_at_ratio(logic signed [15:0] ratio);
      int x;
      int seg;
      longint dx, dy, slope, prod, mag, val;
      x = ratio;
      if (x < knot_x[0]) return 15'(knot_y[0]);
      if (x >= knot_x[21]) return 15'(knot_y[21]);
      seg = 0;
      for (int k = 1; k < 21; k++) begin
         if (knot_x[k] <= x) seg = k;
      end
      dx = knot_x[seg + 1] - knot_x[seg];
      if (dx <= 0) return 15'(knot_y[seg]);
      dy = knot_y[seg + 1] - knot_y[seg];
      mag = (dy < 0) ? -dy : dy;
      mag = (mag * 65536 + dx / 2) / dx;
      slope = (dy < 0) ? -mag : mag;
      prod = longint'(x - knot_x[seg]) * slope;
      mag = (prod < 0) ? -prod : prod;
      mag = (mag + 32768) >>> 16;
      val = knot_y[seg] + ((prod < 0) ? -mag : mag);
      if (val < 0) val = 0;
      if (val > 32767) val = 32767;
      return 15'(val);
   endfunction

   function void note_ratio(logic signed [15:0] ratio);
      expected_values.push_back(curve_at_ratio(ratio));
   endfunction

   task report_mismatch(string text);
      if (mismatches < 100) $display("MISMATCH at %0t: %s", $time, text);
      mismatches++;
   endtask

   task check_value(logic [14:0] value);
      logic [14:0] wanted;
      if (expected_values.size() == 0) begin
         report_mismatch($sformatf("curve_value %0d with no request outstanding", value));
      end else begin
         wanted = expected_values.pop_front();
         if (value !== wanted)
            report_mismatch($sformatf("curve_value %0d, expected %0d", value, wanted));
      end
   endtask
endclass

module tb_piecewise_linear_curve_eval_unit;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit rsp_steady = 1'b0;
   bit req_steady = 1'b0;
   int stall_left = 0;
   int cycle_count = 0;
   curve_value_checker sb = new();

   pwl_req_if req_if();
   pwl_rsp_if rsp_if();

   piecewise_linear_curve_eval_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!rsp_steady && $urandom_range(0, 3) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_ratio(req_if.ratio);
         if (rsp_if.valid && rsp_if.ready) sb.check_value(rsp_if.curve_value);
      end
   end

   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (req_steady || roll < 75) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function logic signed [15:0] pick_ratio();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 16'($urandom_range(0, 9011));
      if (roll < 80) return 16'(sb.knot_x[$urandom_range(0, 21)] + $urandom_range(0, 4) - 2);
      return 16'($urandom);
   endfunction

   task drive_ratio(input logic signed [15:0] ratio, input int gap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ratio <= ratio;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
   endtask

   task drain_requests();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      static logic signed [15:0] directed [$] = '{
         -16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd405, 16'sd406, 16'sd2837, 16'sd2838,
         16'sd2839, 16'sd4049, 16'sd6096, 16'sd8191, 16'sd8192, 16'sd8193, 16'sd9010,
         16'sd9011, 16'sd9012, 16'sh5555, -16'sh5556, 16'sd32767, 16'sd16383, -16'sd16384
      };
      req_if.valid = 1'b0;
      req_if.ratio = '0;
      rsp_if.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) drive_ratio(directed[i], pick_gap());
      drain_requests();

      for (int phase = 0; phase < 8; phase++) begin
         rsp_steady = (phase % 4 == 1);
         req_steady = (phase % 4 == 1) || (phase % 4 == 2);
         for (int n = 0; n < 250; n++) begin
            drive_ratio(pick_ratio(), pick_gap());
            if (phase == 4 && n == 125) drain_requests();
         end
      end

      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

### piecewise_linear_curve_eval_unit.f
+incdir+rtl/core
rtl/core/pwl_pkg.sv
rtl/core/pwl_if.sv
rtl/core/pwl_seg_find.sv
rtl/core/pwl_coef.sv
rtl/core/pwl_mac.sv
rtl/core/piecewise_linear_curve_eval_unit.sv
verif/tb_piecewise_linear_curve_eval_unit.sv
